/* sv/ucmc_pkg.sv */
// Shared constants, types and command tables for the motor command controller.
package ucmc_pkg;

  // Parser.
  localparam int LINE_CAPACITY = 31;
  localparam int POS_W         = $clog2(LINE_CAPACITY + 1);
  localparam int NUM_CMDS      = 5;
  localparam int CMD_TEXT_LEN  = 7;
  localparam int SPEED_W       = 7;
  localparam int ACC_EXT_W     = 10;
  localparam logic [POS_W-1:0]   DIGIT_START = POS_W'(7);
  localparam logic [SPEED_W-1:0] SPEED_MAX   = SPEED_W'(100);
  localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(50);

  localparam int CMD_BUZZER = 0;
  localparam int CMD_MOTOR1 = 1;
  localparam int CMD_MOTOR2 = 2;
  localparam int CMD_SPEED1 = 3;
  localparam int CMD_SPEED2 = 4;

  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [7:0] CMD_TEXT [NUM_CMDS][CMD_TEXT_LEN] = '{
    '{"b", "u", "z", "z", "e", "r", 8'h00},
    '{"m", "o", "t", "o", "r", "1", 8'h00},
    '{"m", "o", "t", "o", "r", "2", 8'h00},
    '{"s", "p", "e", "e", "d", "1", ":"},
    '{"s", "p", "e", "e", "d", "2", ":"}
  };
  localparam logic [POS_W-1:0] CMD_LEN [NUM_CMDS] = '{
    POS_W'(6), POS_W'(6), POS_W'(6), POS_W'(7), POS_W'(7)
  };

  // Item kinds.
  localparam logic [1:0] OP_UART    = 2'd0;
  localparam logic [1:0] OP_BUTTONS = 2'd1;
  localparam logic [1:0] OP_ECHO    = 2'd2;

  // Motor report codes.
  localparam logic [1:0] REP_NONE = 2'd0;
  localparam logic [1:0] REP_ON   = 2'd1;
  localparam logic [1:0] REP_OFF  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_M1_FACTOR = 2'd0;
  localparam logic [1:0] CFG_M2_FACTOR = 2'd1;
  localparam logic [1:0] CFG_STOP_CM   = 2'd2;
  localparam logic [1:0] CFG_PERIOD    = 2'd3;

  localparam int FACTOR_W = 8;
  localparam int PERIOD_W = 16;
  localparam int CFG_W    = 16;

  // Distance: count*195/58000 = count*39/11600, and 11600 = 16*725.
  localparam int ECHO_W        = 24;
  localparam int ECHO_MUL      = 39;
  localparam int ECHO_X_W      = 30;
  localparam int ECHO_PRE      = 4;
  localparam int ECHO_SCALED_W = ECHO_X_W - ECHO_PRE;
  localparam int DIST_DIV      = 725;
  localparam int DIST_SHIFT    = 36;
  localparam int DIST_RECIP_W  = 27;
  localparam logic [DIST_RECIP_W-1:0] DIST_RECIP =
    DIST_RECIP_W'(((64'd1 << DIST_SHIFT) + 64'(DIST_DIV) - 64'd1) / 64'(DIST_DIV));
  localparam int DIST_PROD_W = ECHO_SCALED_W + DIST_RECIP_W;
  localparam int DIST_W      = 16;

  // Duty: period*speed*factor/1000 = ((period*sf) >> 3) / 125.
  localparam int SF_W         = SPEED_W + FACTOR_W;
  localparam int PS_FULL_W    = SF_W + PERIOD_W;
  localparam int DUTY_PRE     = 3;
  localparam int PS_W         = PS_FULL_W - DUTY_PRE;
  localparam int DUTY_DIV     = 125;
  localparam int DUTY_SHIFT   = 35;
  localparam int DUTY_RECIP_W = 29;
  localparam logic [DUTY_RECIP_W-1:0] DUTY_RECIP =
    DUTY_RECIP_W'(((64'd1 << DUTY_SHIFT) + 64'(DUTY_DIV) - 64'd1) / 64'(DUTY_DIV));
  localparam int DUTY_PROD_W  = PS_W + DUTY_RECIP_W;
  localparam int Q_W          = DUTY_PROD_W - DUTY_SHIFT;
  localparam int DUTY_W       = 16;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [FACTOR_W-1:0] m1_factor;
    logic [FACTOR_W-1:0] m2_factor;
    logic [7:0]          stop_cm;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic               tog1;
    logic               tog2;
    logic               buzz;
    logic               set1;
    logic               set2;
    logic [SPEED_W-1:0] speed_val;
    logic               dvalid;
  } action_t;

  typedef struct packed {
    action_t                  act;
    logic [ECHO_SCALED_W-1:0] echo_scaled;
  } front_item_t;

  typedef struct packed {
    action_t           act;
    logic [DIST_W-1:0] dist_cm;
  } queue_item_t;

  typedef struct packed {
    logic              run1;
    logic              run2;
    logic [1:0]        rep1;
    logic [1:0]        rep2;
    logic              buzz;
    logic              stop;
    logic              dvalid;
    logic [DIST_W-1:0] dist_cm;
  } flags_t;

  typedef struct packed {
    logic              motor1_enabled;
    logic              motor2_enabled;
    logic [DUTY_W-1:0] motor1_duty;
    logic [DUTY_W-1:0] motor2_duty;
    logic [1:0]        motor1_report;
    logic [1:0]        motor2_report;
    logic              buzzer_pulse;
    logic              collision_stop;
    logic              distance_valid;
    logic [DIST_W-1:0] distance_cm;
  } result_t;

endpackage

/* sv/ucmc_front.sv */
// Front end: accepts requests, runs the line parser and button edge logic, scales echo counts.
module ucmc_front import ucmc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [7:0]        rx_byte,
  input  logic              button1_level,
  input  logic              button2_level,
  input  logic [ECHO_W-1:0] echo_count,
  output logic              q_push,
  output queue_item_t       q_item,
  input  logic              q_full
);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [NUM_CMDS-1:0] cand_r, cand_nxt;
  logic [SPEED_W-1:0]  acc_r, acc_nxt;
  logic                ended_r, ended_nxt;
  logic                btn1_prev_r, btn1_prev_nxt;
  logic                btn2_prev_r, btn2_prev_nxt;
  logic                s1_valid_r;
  front_item_t         s1_r, s1_nxt;
  logic                accept;
  logic [NUM_CMDS-1:0] fire;
  logic [ACC_EXT_W-1:0] acc_ext;
  logic [ECHO_X_W-1:0]  echo_x;
  logic [DIST_PROD_W-1:0] dist_prod;

  assign in_ready = !s1_valid_r || !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = s1_valid_r && !q_full;

  assign acc_ext = ACC_EXT_W'(acc_r) * ACC_EXT_W'(10) + ACC_EXT_W'(rx_byte[3:0]);
  assign echo_x  = ECHO_X_W'(echo_count) * ECHO_X_W'(ECHO_MUL);

  always_comb begin
    pos_nxt       = pos_r;
    cand_nxt      = cand_r;
    acc_nxt       = acc_r;
    ended_nxt     = ended_r;
    btn1_prev_nxt = btn1_prev_r;
    btn2_prev_nxt = btn2_prev_r;
    s1_nxt        = '0;
    for (int k = 0; k < NUM_CMDS; k++) begin
      fire[k] = cand_r[k] && (pos_r >= CMD_LEN[k]);
    end
    unique case (op)
      OP_UART: begin
        if (rx_byte == CHAR_LF) begin
          s1_nxt.act.buzz      = fire[CMD_BUZZER];
          s1_nxt.act.tog1      = fire[CMD_MOTOR1];
          s1_nxt.act.tog2      = fire[CMD_MOTOR2];
          s1_nxt.act.set1      = fire[CMD_SPEED1];
          s1_nxt.act.set2      = fire[CMD_SPEED2];
          s1_nxt.act.speed_val = acc_r;
          pos_nxt   = '0;
          cand_nxt  = '1;
          acc_nxt   = '0;
          ended_nxt = 1'b0;
        end else if (rx_byte != CHAR_CR && pos_r < POS_W'(LINE_CAPACITY)) begin
          for (int k = 0; k < NUM_CMDS; k++) begin
            if (pos_r < CMD_LEN[k] && rx_byte != CMD_TEXT[k][pos_r[2:0]]) begin
              cand_nxt[k] = 1'b0;
            end
          end
          if (pos_r >= DIGIT_START && !ended_r) begin
            if (rx_byte >= CHAR_ZERO && rx_byte <= CHAR_NINE) begin
              acc_nxt = (acc_ext > ACC_EXT_W'(SPEED_MAX)) ? SPEED_MAX : acc_ext[SPEED_W-1:0];
            end else begin
              ended_nxt = 1'b1;
            end
          end
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      OP_BUTTONS: begin
        s1_nxt.act.tog1 = !button1_level && btn1_prev_r;
        s1_nxt.act.tog2 = !button2_level && btn2_prev_r;
        btn1_prev_nxt   = button1_level;
        btn2_prev_nxt   = button2_level;
      end
      OP_ECHO: begin
        s1_nxt.act.dvalid  = 1'b1;
        s1_nxt.echo_scaled = echo_x[ECHO_X_W-1:ECHO_PRE];
      end
      default: begin
        s1_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cand_r      <= '1;
      acc_r       <= '0;
      ended_r     <= 1'b0;
      btn1_prev_r <= 1'b1;
      btn2_prev_r <= 1'b1;
      s1_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        pos_r       <= pos_nxt;
        cand_r      <= cand_nxt;
        acc_r       <= acc_nxt;
        ended_r     <= ended_nxt;
        btn1_prev_r <= btn1_prev_nxt;
        btn2_prev_r <= btn2_prev_nxt;
        s1_valid_r  <= 1'b1;
      end else if (q_push) begin
        s1_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // Reciprocal multiply finishes the division by 725; the queue entry registers it.
  assign dist_prod      = DIST_PROD_W'(s1_r.echo_scaled) * DIST_PROD_W'(DIST_RECIP);
  assign q_item.act     = s1_r.act;
  assign q_item.dist_cm = dist_prod[DIST_SHIFT +: DIST_W];

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(LINE_CAPACITY))
    else $error("line position passed capacity");

  a_acc_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r <= SPEED_MAX)
    else $error("digit accumulator above saturation value");

  a_newline_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && op == OP_UART && rx_byte == CHAR_LF
    |=> pos_r == '0 && cand_r == '1 && acc_r == '0 && !ended_r)
    else $error("parser not cleared after newline");

endmodule

/* sv/ucmc_queue.sv */
// Short register queue that decouples the front end from the back end.
module ucmc_queue import ucmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  queue_item_t push_item,
  output logic        full,
  input  logic        pop,
  output queue_item_t head,
  output logic        nonempty
);

  queue_item_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign nonempty = cnt_r != '0;
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + QCNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - QCNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> nonempty)
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

/* sv/ucmc_back.sv */
// Back end: applies queued actions to motor state and pipelines the duty arithmetic.
module ucmc_back import ucmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_nonempty,
  input  queue_item_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  logic               adv;
  logic               run1_r, run1_nxt, run2_r, run2_nxt;
  logic [SPEED_W-1:0] spd1_r, spd1_nxt, spd2_r, spd2_nxt;
  logic               coll;
  flags_t             f0_nxt;

  logic               v0_r, v1_r, v2_r, v3_r, out_valid_r;
  flags_t             f0_r, f1_r, f2_r, f3_r;
  logic [SPEED_W-1:0] sp1_0_r, sp2_0_r;
  logic [SF_W-1:0]    sf1_r, sf2_r;
  logic [PS_W-1:0]    ps1_r, ps2_r;
  logic [Q_W-1:0]     q1_r, q2_r;
  result_t            out_r;

  logic [PS_FULL_W-1:0]   pfull1, pfull2;
  logic [DUTY_PROD_W-1:0] dprod1, dprod2;

  function automatic logic [DUTY_W-1:0] duty_final(input logic run, input logic [Q_W-1:0] q,
                                                   input logic [PERIOD_W-1:0] period);
    logic [DUTY_W-1:0] d;
    d = (q > Q_W'(period)) ? period : q[DUTY_W-1:0];
    if (!run || d == '0) begin
      d = DUTY_W'(1);
    end
    return d;
  endfunction

  assign adv       = !out_valid_r || out_ready;
  assign q_pop     = q_nonempty && adv;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Apply one queued action to the running state.
  always_comb begin
    coll     = q_head.act.dvalid && q_head.dist_cm != '0 &&
               q_head.dist_cm <= DIST_W'(cfg.stop_cm);
    run1_nxt = !coll && (run1_r ^ q_head.act.tog1);
    run2_nxt = !coll && (run2_r ^ q_head.act.tog2);
    spd1_nxt = q_head.act.set1 ? q_head.act.speed_val : spd1_r;
    spd2_nxt = q_head.act.set2 ? q_head.act.speed_val : spd2_r;
    f0_nxt.run1    = run1_nxt;
    f0_nxt.run2    = run2_nxt;
    f0_nxt.rep1    = q_head.act.tog1 ? (run1_nxt ? REP_ON : REP_OFF) : REP_NONE;
    f0_nxt.rep2    = q_head.act.tog2 ? (run2_nxt ? REP_ON : REP_OFF) : REP_NONE;
    f0_nxt.buzz    = q_head.act.buzz;
    f0_nxt.stop    = coll;
    f0_nxt.dvalid  = q_head.act.dvalid;
    f0_nxt.dist_cm = q_head.dist_cm;
  end

  assign pfull1 = PS_FULL_W'(sf1_r) * PS_FULL_W'(cfg.period);
  assign pfull2 = PS_FULL_W'(sf2_r) * PS_FULL_W'(cfg.period);
  assign dprod1 = DUTY_PROD_W'(ps1_r) * DUTY_PROD_W'(DUTY_RECIP);
  assign dprod2 = DUTY_PROD_W'(ps2_r) * DUTY_PROD_W'(DUTY_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run1_r      <= 1'b0;
      run2_r      <= 1'b0;
      spd1_r      <= SPEED_RESET;
      spd2_r      <= SPEED_RESET;
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        run1_r <= run1_nxt;
        run2_r <= run2_nxt;
        spd1_r <= spd1_nxt;
        spd2_r <= spd2_nxt;
      end
      if (adv) begin
        v0_r        <= q_pop;
        v1_r        <= v0_r;
        v2_r        <= v1_r;
        v3_r        <= v2_r;
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_r    <= f0_nxt;
      sp1_0_r <= spd1_nxt;
      sp2_0_r <= spd2_nxt;

      f1_r  <= f0_r;
      sf1_r <= SF_W'(sp1_0_r) * SF_W'(cfg.m1_factor);
      sf2_r <= SF_W'(sp2_0_r) * SF_W'(cfg.m2_factor);

      f2_r  <= f1_r;
      ps1_r <= pfull1[PS_FULL_W-1:DUTY_PRE];
      ps2_r <= pfull2[PS_FULL_W-1:DUTY_PRE];

      f3_r <= f2_r;
      q1_r <= dprod1[DUTY_SHIFT +: Q_W];
      q2_r <= dprod2[DUTY_SHIFT +: Q_W];

      out_r.motor1_enabled <= f3_r.run1;
      out_r.motor2_enabled <= f3_r.run2;
      out_r.motor1_duty    <= duty_final(f3_r.run1, q1_r, cfg.period);
      out_r.motor2_duty    <= duty_final(f3_r.run2, q2_r, cfg.period);
      out_r.motor1_report  <= f3_r.rep1;
      out_r.motor2_report  <= f3_r.rep2;
      out_r.buzzer_pulse   <= f3_r.buzz;
      out_r.collision_stop <= f3_r.stop;
      out_r.distance_valid <= f3_r.dvalid;
      out_r.distance_cm    <= f3_r.dist_cm;
    end
  end

  a_off_duty_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.motor1_enabled |-> out_r.motor1_duty == DUTY_W'(1))
    else $error("motor one off but duty is not one");

  a_stop_turns_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.collision_stop |-> !out_r.motor1_enabled && !out_r.motor2_enabled)
    else $error("collision stop with a motor still running");

  a_report_on_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.motor2_report == REP_ON |-> out_r.motor2_enabled)
    else $error("motor two reported on while not running");

  a_duty_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.motor1_duty <= cfg.period || out_r.motor1_duty == DUTY_W'(1))
    else $error("motor one duty above period");

endmodule

/* sv/uart_motor_command_controller.sv */
// Top level of the two-motor command controller: configuration registers and stream ports.
//
//   Channel  Direction  Handshake            Payload
//   in_      slave      in_tvalid/in_tready  tdata: command byte, buttons, echo; tuser: kind
//   out_     master     out_tvalid/out_tready tdata: motor state, duties, reports, distance
//   cfg_     write      cfg_we               cfg_index selects, cfg_wdata carries the value
//
// One request can be taken every clock cycle while in_tready is high. Each request gives one
// result, and on its way passes one front-end register, the four-entry queue,
// and the four back-end stages of the duty arithmetic before the output register.
// Reset is synchronous on rst_n and clears all control and motor state at once.
// A stall on the output holds the back end; the front end keeps taking requests until the
// queue is full, and only then drops in_tready.
//
// Each request is one of three kinds, chosen by in_tuser. A received character drives a line
// parser that matches the buzzer, motor1, motor2, speed1: and speed2: prefixes byte by byte,
// so no line buffer is kept; a newline fires whichever command matched. A button sample
// toggles a motor on a falling level. An echo count is turned into centimeters, and a short
// distance inside the stop limit switches both motors off. Each result shows the motor state
// after the request, with duties derived from speed, factor and the pwm period.
module uart_motor_command_controller import ucmc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // rx_byte [7:0], button1_level [8], button2_level [9], echo_count [33:10], zero pad
  input  logic [39:0]           in_tdata,
  // op [1:0]
  input  logic [1:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // motor1_enabled [0], motor2_enabled [1], motor1_duty [17:2], motor2_duty [33:18],
  // motor1_report [35:34], motor2_report [37:36], buzzer_pulse [38], collision_stop [39],
  // distance_cm [55:40]
  output logic [55:0]           out_tdata,
  // distance_valid [0]
  output logic [0:0]            out_tuser,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  cfg_t        cfg_r;
  logic        q_push, q_full, q_pop, q_nonempty;
  queue_item_t q_item, q_head;
  result_t     res;

  // The user must write the registers only while no request is in flight; the block does not
  // enforce this, and the back end reads the registers directly at every stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.m1_factor <= FACTOR_W'(19);
      cfg_r.m2_factor <= FACTOR_W'(35);
      cfg_r.stop_cm   <= 8'd3;
      cfg_r.period    <= PERIOD_W'(1000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_M1_FACTOR: cfg_r.m1_factor <= cfg_wdata[FACTOR_W-1:0];
        CFG_M2_FACTOR: cfg_r.m2_factor <= cfg_wdata[FACTOR_W-1:0];
        CFG_STOP_CM:   cfg_r.stop_cm   <= cfg_wdata[7:0];
        CFG_PERIOD:    cfg_r.period    <= cfg_wdata[PERIOD_W-1:0];
      endcase
    end
  end

  ucmc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .op            (in_tuser),
    .rx_byte       (in_tdata[7:0]),
    .button1_level (in_tdata[8]),
    .button2_level (in_tdata[9]),
    .echo_count    (in_tdata[33:10]),
    .q_push        (q_push),
    .q_item        (q_item),
    .q_full        (q_full)
  );

  ucmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  ucmc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = {res.distance_cm, res.collision_stop, res.buzzer_pulse,
                      res.motor2_report, res.motor1_report, res.motor2_duty,
                      res.motor1_duty, res.motor2_enabled, res.motor1_enabled};
  assign out_tuser = res.distance_valid;

endmodule
